@@ src/pkfs_pkg.sv @@
// Shared types and constants of the pre-record key-frame start finder.
`timescale 1ns / 1ps
`default_nettype none

package pkfs_pkg;

   localparam int SID_W  = 4;
   localparam int TIME_W = 64;
   localparam int CNT_W  = 11;
   localparam int POS_W  = 10;

   localparam logic KIND_STORE  = 1'b0;
   localparam logic KIND_SEARCH = 1'b1;

   typedef struct packed {
      logic              key;
      logic [SID_W-1:0]  sid;
      logic [TIME_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

`default_nettype wire

@@ src/pkfs_ram.sv @@
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps
`default_nettype none

module pkfs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]              rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

@@ src/prerecord_keyframe_start_finder.sv @@
// Top level of the pre-record key-frame start finder: ring store and backward search.
// Stores may follow each other in every cycle while no search runs. A search transfer walks
// the ring backward through the single read port of the descriptor memory, one entry per
// cycle, at most RING_DEPTH entries; a finished search then waits in the drain state while
// an earlier result still sits unaccepted in the result register. No item is taken while a
// search runs. The result register frees the search engine, so stores keep flowing while a
// result waits. Occupancy is tracked with a fill count, so there is no clearing pass after
// reset.
`timescale 1ns / 1ps
`default_nettype none

module prerecord_keyframe_start_finder #(
   parameter int RING_DEPTH = 1024
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_valid,
   output logic                             req_ready,
   input  wire logic                        req_kind,
   input  wire logic [pkfs_pkg::SID_W-1:0]  req_stream_id,
   input  wire logic [pkfs_pkg::TIME_W-1:0] req_time_stamp,
   input  wire logic                        req_key_frame,
   input  wire logic [pkfs_pkg::CNT_W-1:0]  req_back_count,
   output logic                             rsp_valid,
   input  wire logic                        rsp_ready,
   output logic [pkfs_pkg::POS_W-1:0]       rsp_start_position
);

   import pkfs_pkg::*;

   localparam int AW = $clog2(RING_DEPTH);
   localparam int DW = $clog2(RING_DEPTH) + 2;
   localparam logic [AW-1:0] LAST_ADDR = AW'(RING_DEPTH - 1);
   localparam logic [DW-1:0] FULL_DIST = DW'(RING_DEPTH);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_DRAIN = 2'd2;

   function automatic logic [AW-1:0] ring_prev(input logic [AW-1:0] p);
      return (p == '0) ? LAST_ADDR : p - AW'(1);
   endfunction

   function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] p);
      return (p == LAST_ADDR) ? '0 : p + AW'(1);
   endfunction

   logic [1:0]        state_ff, state_in;
   logic [AW-1:0]     wp_ff, wp_in;
   logic [DW-1:0]     fill_ff, fill_in;
   logic [SID_W-1:0]  q_sid_ff, q_sid_in;
   logic [TIME_W-1:0] q_time_ff, q_time_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              phase_ff, phase_in;
   logic [AW-1:0]     iss_addr_ff, iss_addr_in;
   logic [DW-1:0]     iss_dist_ff, iss_dist_in;
   logic              dat_valid_ff, dat_valid_in;
   logic [AW-1:0]     dat_addr_ff, dat_addr_in;
   logic [DW-1:0]     dat_dist_ff, dat_dist_in;
   logic [AW-1:0]     res_ff, res_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_pos_ff, rsp_pos_in;

   logic              req_fire;
   logic              wr_en;
   entry_type         wr_entry;
   logic [ENTRY_W-1:0] rd_data;
   entry_type         rd_entry;
   logic              hit_empty;
   logic              hit_sid;
   logic              hit_time;
   logic [CNT_W-1:0]  cnt_dec;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign wr_en     = req_fire && (req_kind == KIND_STORE);

   assign wr_entry.key   = req_key_frame;
   assign wr_entry.sid   = req_stream_id;
   assign wr_entry.stamp = req_time_stamp;

   pkfs_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wp_ff),
      .wr_data (wr_entry),
      .rd_addr (iss_addr_ff),
      .rd_data (rd_data)
   );

   assign rd_entry  = entry_type'(rd_data);
   assign hit_empty = (dat_dist_ff > fill_ff) || (dat_dist_ff == FULL_DIST);
   assign hit_sid   = (rd_entry.sid == q_sid_ff);
   assign hit_time  = ($signed(rd_entry.stamp) <= $signed(q_time_ff));
   assign cnt_dec   = (hit_sid && (count_ff != '0)) ? count_ff - CNT_W'(1) : count_ff;

   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      fill_in      = fill_ff;
      q_sid_in     = q_sid_ff;
      q_time_in    = q_time_ff;
      count_in     = count_ff;
      phase_in     = phase_ff;
      iss_addr_in  = iss_addr_ff;
      iss_dist_in  = iss_dist_ff;
      dat_valid_in = dat_valid_ff;
      dat_addr_in  = dat_addr_ff;
      dat_dist_in  = dat_dist_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_pos_in   = rsp_pos_ff;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_kind == KIND_STORE) begin
                  wp_in = ring_next(wp_ff);
                  if (fill_ff != FULL_DIST) begin
                     fill_in = fill_ff + DW'(1);
                  end
               end else begin
                  state_in     = ST_SCAN;
                  q_sid_in     = req_stream_id;
                  q_time_in    = req_time_stamp;
                  count_in     = req_back_count;
                  phase_in     = 1'b0;
                  iss_addr_in  = ring_prev(wp_ff);
                  iss_dist_in  = DW'(1);
                  dat_valid_in = 1'b0;
               end
            end
         end
         ST_SCAN: begin
            dat_valid_in = 1'b1;
            dat_addr_in  = iss_addr_ff;
            dat_dist_in  = iss_dist_ff;
            iss_addr_in  = ring_prev(iss_addr_ff);
            iss_dist_in  = iss_dist_ff + DW'(1);
            if (dat_valid_ff) begin
               if (hit_empty) begin
                  res_in       = ring_next(dat_addr_ff);
                  state_in     = ST_DRAIN;
                  dat_valid_in = 1'b0;
               end else if (!phase_ff) begin
                  if (hit_sid && hit_time) begin
                     phase_in = 1'b1;
                     if ((count_ff == '0) && rd_entry.key) begin
                        res_in       = dat_addr_ff;
                        state_in     = ST_DRAIN;
                        dat_valid_in = 1'b0;
                     end
                  end
               end else begin
                  count_in = cnt_dec;
                  if ((cnt_dec == '0) && hit_sid && rd_entry.key) begin
                     res_in       = dat_addr_ff;
                     state_in     = ST_DRAIN;
                     dat_valid_in = 1'b0;
                  end
               end
            end
         end
         ST_DRAIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = POS_W'(res_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wp_ff        <= '0;
         fill_ff      <= '0;
         dat_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wp_ff        <= wp_in;
         fill_ff      <= fill_in;
         dat_valid_ff <= dat_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      q_sid_ff    <= q_sid_in;
      q_time_ff   <= q_time_in;
      count_ff    <= count_in;
      phase_ff    <= phase_in;
      iss_addr_ff <= iss_addr_in;
      iss_dist_ff <= iss_dist_in;
      dat_addr_ff <= dat_addr_in;
      dat_dist_ff <= dat_dist_in;
      res_ff      <= res_in;
      rsp_pos_ff  <= rsp_pos_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_start_position = rsp_pos_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FULL_DIST)
      else $error("fill count exceeds ring depth");

   a_wp_tracks_fill: assert property (@(posedge clock) disable iff (reset)
      (fill_ff != FULL_DIST) |-> (DW'(wp_ff) == fill_ff))
      else $error("write pointer out of step with fill count before wrap");

   a_data_only_in_scan: assert property (@(posedge clock) disable iff (reset)
      dat_valid_ff |-> (state_ff == ST_SCAN))
      else $error("memory data stage active outside of a scan");

   a_search_starts_scan: assert property (@(posedge clock) disable iff (reset)
      (req_fire && (req_kind == KIND_SEARCH)) |=> (state_ff == ST_SCAN) && !dat_valid_ff)
      else $error("search transfer did not start a scan");

   a_drain_delivers: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_DRAIN) && (!rsp_valid_ff || rsp_ready))
         |=> rsp_valid_ff && (state_ff == ST_IDLE))
      else $error("finished search was not delivered");

endmodule

`default_nettype wire
